// ===== src/ssp_pkg.sv =====
// Shared types for the stable sort with permutation parity block.
`timescale 1ns / 1ps

package ssp_pkg;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic ins; // insert the broadcast word behind all keys >= it
		logic pop; // shift the chain toward cell 0 by one place
	} ssp_ctrl_t;

endpackage

// ===== src/ssp_cell.sv =====
// One cell of the sorted insertion chain: holds one key and its code.
`timescale 1ns / 1ps

module ssp_cell #(
	parameter int TIME_BITS = 24,
	parameter int OP_BITS   = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ssp_pkg::ssp_ctrl_t    ctrl,
	input  logic [TIME_BITS-1:0]  new_key,
	input  logic [OP_BITS-1:0]    new_code,
	input  logic                  left_keep,
	input  logic                  left_valid,
	input  logic [TIME_BITS-1:0]  left_key,
	input  logic [OP_BITS-1:0]    left_code,
	input  logic                  right_valid,
	input  logic [TIME_BITS-1:0]  right_key,
	input  logic [OP_BITS-1:0]    right_code,
	output logic                  valid,
	output logic [TIME_BITS-1:0]  key,
	output logic [OP_BITS-1:0]    code,
	output logic                  keep
);
	import ssp_pkg::*;

	logic                 valid_q;
	logic [TIME_BITS-1:0] key_q;
	logic [OP_BITS-1:0]   code_q;

	assign keep  = valid_q && (key_q >= new_key);
	assign valid = valid_q;
	assign key   = key_q;
	assign code  = code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= right_valid;
		end else if (ctrl.ins && !keep) begin
			valid_q <= left_keep ? 1'b1 : left_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			key_q  <= right_key;
			code_q <= right_code;
		end else if (ctrl.ins && !keep) begin
			if (left_keep) begin
				key_q  <= new_key;
				code_q <= new_code;
			end else begin
				key_q  <= left_key;
				code_q <= left_code;
			end
		end
	end

endmodule

// ===== src/stable_sort_with_permutation_parity_core.sv =====
// Top level: stable descending sort of a word sequence with permutation sign.
//
// Input channel (in_valid/in_ready): one word per cycle carries time_key,
// op_code and last_in. Each accepted word is inserted into a chain of
// MAX_ORDER cells, behind every stored key >= its own, so equal
// keys keep arrival order. Words arriving with the chain full are dropped and
// set the overflow flag. The word with last_in set ends the run.
// Output channel (out_valid/out_ready): after the last word, the stored words
// leave in descending key order, one per cycle, from cell 0 while the chain
// shifts toward it. Every output word carries sign_negative and overflow of
// the run; last_out marks the final one. The first output word is valid the
// cycle after the last input word is accepted.
// in_ready is low while a run is being emitted, so a new run is taken only
// after the last word of the previous run has left. A stalled receiver
// simply holds the chain.
// Reset clears all cell valid bits, the count, parity and overflow state.
`timescale 1ns / 1ps

module stable_sort_with_permutation_parity_core #(
	parameter int MAX_ORDER = 16,
	parameter int TIME_BITS = 24,
	parameter int OP_BITS   = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TIME_BITS-1:0] time_key,
	input  logic [OP_BITS-1:0]   op_code,
	input  logic                 last_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [TIME_BITS-1:0] sorted_time,
	output logic [OP_BITS-1:0]   sorted_op,
	output logic                 sign_negative,
	output logic                 overflow,
	output logic                 last_out
);
	import ssp_pkg::*;

	localparam int CW = $clog2(MAX_ORDER + 1);

	logic                 emit_q;
	logic [CW-1:0]        cnt_q;
	logic                 parity_q;
	logic                 ovf_q;

	logic                 in_acc;
	logic                 out_acc;
	logic                 full;
	ssp_ctrl_t            ctrl;

	logic [MAX_ORDER-1:0] vld_w;
	logic [MAX_ORDER-1:0] keep_w;
	logic [TIME_BITS-1:0] key_w  [MAX_ORDER];
	logic [OP_BITS-1:0]   code_w [MAX_ORDER];
	logic                 ins_par;

	assign in_ready = !emit_q;
	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;
	assign full     = (cnt_q == CW'(MAX_ORDER));

	assign ctrl.ins = in_acc && !full;
	assign ctrl.pop = out_acc;

	// cells after the insertion point hold strictly smaller keys
	assign ins_par = ^(vld_w & ~keep_w);

	for (genvar i = 0; i < MAX_ORDER; i++) begin : g_cell
		logic                 lk;
		logic                 lv;
		logic [TIME_BITS-1:0] lkey;
		logic [OP_BITS-1:0]   lcode;
		logic                 rv;
		logic [TIME_BITS-1:0] rkey;
		logic [OP_BITS-1:0]   rcode;

		if (i == 0) begin : g_head
			assign lk    = 1'b1;
			assign lv    = 1'b0;
			assign lkey  = '0;
			assign lcode = '0;
		end else begin : g_body
			assign lk    = keep_w[i-1];
			assign lv    = vld_w[i-1];
			assign lkey  = key_w[i-1];
			assign lcode = code_w[i-1];
		end

		if (i == MAX_ORDER - 1) begin : g_tail
			assign rv    = 1'b0;
			assign rkey  = '0;
			assign rcode = '0;
		end else begin : g_next
			assign rv    = vld_w[i+1];
			assign rkey  = key_w[i+1];
			assign rcode = code_w[i+1];
		end

		ssp_cell #(
			.TIME_BITS(TIME_BITS),
			.OP_BITS  (OP_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_key    (time_key),
			.new_code   (op_code),
			.left_keep  (lk),
			.left_valid (lv),
			.left_key   (lkey),
			.left_code  (lcode),
			.right_valid(rv),
			.right_key  (rkey),
			.right_code (rcode),
			.valid      (vld_w[i]),
			.key        (key_w[i]),
			.code       (code_w[i]),
			.keep       (keep_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q   <= 1'b0;
			cnt_q    <= '0;
			parity_q <= 1'b0;
			ovf_q    <= 1'b0;
		end else if (emit_q) begin
			if (out_acc) begin
				if (cnt_q == CW'(1)) begin
					emit_q   <= 1'b0;
					cnt_q    <= '0;
					parity_q <= 1'b0;
					ovf_q    <= 1'b0;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end else if (in_acc) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				cnt_q    <= cnt_q + CW'(1);
				parity_q <= parity_q ^ ins_par;
			end
			if (last_in) begin
				emit_q <= 1'b1;
			end
		end
	end

	assign out_valid     = emit_q;
	assign sorted_time   = key_w[0];
	assign sorted_op     = code_w[0];
	assign sign_negative = parity_q;
	assign overflow      = ovf_q;
	assign last_out      = (cnt_q == CW'(1));

`ifndef ASSERT_OFF
	a_cnt_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_w) == 32'(cnt_q))
		else $error("cell valid bits disagree with item count");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ORDER))
		else $error("item count beyond capacity");

	a_emit_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> vld_w[0])
		else $error("emitting from an empty chain");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_out) |=> (!out_valid && cnt_q == '0 && !parity_q && !ovf_q))
		else $error("run state not cleared after final word");
`endif

endmodule
